@@ sv/ipv4_header_rx_check_top_defines.svh @@
// Assertion macros for the IPv4 receive check RTL (used by ipv4rx_hdr_proc).
// No dependencies; included by files that carry concurrent assertions.
`ifndef IPV4_HEADER_RX_CHECK_TOP_DEFINES_SVH
`define IPV4_HEADER_RX_CHECK_TOP_DEFINES_SVH

// Checked on clk_i, off while rst_ni is low.
`define IPV4RX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on clk_i at every edge, reset included.
`define IPV4RX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ sv/ipv4rx_pkg.sv @@
// Types and constants for the IPv4 receive header check.
// No dependencies; imported by ipv4rx_hdr_proc and ipv4_header_rx_check_top.
`default_nettype none

package ipv4rx_pkg;

  localparam int unsigned PosW    = 5;
  localparam int unsigned CfgIdxW = 1;

  // Word positions within the frame (Ethernet header is words 0..6).
  localparam logic [PosW-1:0] MacFirst   = 5'd3;
  localparam logic [PosW-1:0] MacLast    = 5'd5;
  localparam logic [PosW-1:0] EthWords   = 5'd7;
  localparam logic [PosW-1:0] LastWord   = 5'd16;
  localparam logic [PosW-1:0] DonePos    = 5'd17;

  // Word offsets within the IPv4 header.
  localparam logic [PosW-1:0] ProtoIndex = 5'd4;
  localparam logic [PosW-1:0] CksumIndex = 5'd5;
  localparam logic [PosW-1:0] SrcIpHi    = 5'd6;
  localparam logic [PosW-1:0] SrcIpLo    = 5'd7;
  localparam logic [PosW-1:0] DstIpHi    = 5'd8;
  localparam logic [PosW-1:0] DstIpLo    = 5'd9;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOwnIp   = 1'b0,
    CfgBcastIp = 1'b1
  } ipv4rx_cfg_idx_e;

  typedef struct packed {
    logic [15:0] frame_word;
    logic        first_word;
  } ipv4rx_in_t;

  typedef struct packed {
    logic        addressed;
    logic [7:0]  protocol;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
  } ipv4rx_out_t;

  typedef struct packed {
    logic [31:0] own_ip;
    logic [31:0] broadcast_ip;
  } ipv4rx_cfg_t;

endpackage

`default_nettype wire

@@ sv/ipv4_header_rx_check_top.sv @@
// Top level of the IPv4 receive header check: handshakes, config registers, staging.
// Depends on ipv4rx_pkg and ipv4rx_hdr_proc.
`default_nettype none

// Receive-side IPv4 header check. Frame words (16 bits, big-endian) enter one
// per transaction on the input channel; first_word restarts the frame count.
// Words 0..6 are the Ethernet header, 7..16 an option-free IPv4 header. On
// word 16 one result transaction leaves with the source MAC, source IP, the
// addressed flag (destination equals own_ip or broadcast_ip) and the
// protocol byte, forced to zero unless addressed and the header checksum
// verifies. Other words give no result. Throughput is one word per clock
// unless a result waits on a stalled output: the only per-word dependency
// is the 16-bit end-around-carry add on the running sum. The accepted word
// 16 passes the input register, then the result register, before its result
// leaves. Both channels use valid/stall; the output register lets the next
// word in while a result waits. Config writes (index 0 own_ip, 1
// broadcast_ip) are always ready and must be issued while the block is idle.
module ipv4_header_rx_check_top
  import ipv4rx_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire ipv4rx_in_t         in_data_i,
  // output channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output ipv4rx_out_t             out_data_o,
  // config write channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  ipv4rx_cfg_t cfg_q;
  logic        in_valid_q;
  ipv4rx_in_t  in_data_q;
  logic        out_valid_q;
  ipv4rx_out_t out_data_q;
  logic        step, out_free, res_last;
  ipv4rx_out_t res;

  // Config registers; writes never stall.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_ip       <= '0;
      cfg_q.broadcast_ip <= '1;
    end else if (cfg_valid_i) begin
      unique case (ipv4rx_cfg_idx_e'(cfg_index_i))
        CfgOwnIp:   cfg_q.own_ip       <= cfg_data_i;
        CfgBcastIp: cfg_q.broadcast_ip <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // A word in the input register moves on unless it makes a result and the
  // result register is still held by a stalled transaction.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && (!res_last || out_free);
  assign in_stall_o = in_valid_q && !step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  ipv4rx_hdr_proc u_hdr_proc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (in_data_q),
    .cfg_i      (cfg_q),
    .res_last_o (res_last),
    .res_o      (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && res_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && step && res_last) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

@@ sv/ipv4rx_hdr_proc.sv @@
// Per-word header state: capture, ones' complement sum, result forming.
// Depends on ipv4rx_pkg and ipv4_header_rx_check_top_defines.svh.
`default_nettype none

`include "ipv4_header_rx_check_top_defines.svh"

module ipv4rx_hdr_proc
  import ipv4rx_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire ipv4rx_in_t  item_i,
  input  wire ipv4rx_cfg_t cfg_i,
  output logic             res_last_o,
  output ipv4rx_out_t      res_o
);

  logic [PosW-1:0] pos_q, pos_d, pos, h;
  logic [15:0]     sum_q, sum_d, sum_base, sum_fold, cksum_q, cksum_d;
  logic [16:0]     sum_raw;
  logic [31:0]     dest_q, dest_d, src_q, src_d;
  logic [47:0]     mac_q, mac_d;
  logic [7:0]      proto_q, proto_d;
  logic [15:0]     w;
  logic            hit, good;

  assign w        = item_i.frame_word;
  assign pos      = item_i.first_word ? '0 : pos_q;
  assign sum_base = item_i.first_word ? '0 : sum_q;
  assign h        = pos - EthWords;

  // end-around carry; cannot overflow a second time
  assign sum_raw  = {1'b0, sum_base} + {1'b0, w};
  assign sum_fold = sum_raw[15:0] + {15'd0, sum_raw[16]};

  always_comb begin
    pos_d   = pos_q;
    sum_d   = sum_q;
    cksum_d = cksum_q;
    dest_d  = dest_q;
    src_d   = src_q;
    mac_d   = mac_q;
    proto_d = proto_q;
    if (step_i) begin
      pos_d = pos;
      sum_d = sum_base;
      if (pos < DonePos) begin
        pos_d = pos + 5'd1;
        if (pos >= MacFirst && pos <= MacLast) begin
          mac_d = {mac_q[31:0], w};
        end
        if (pos >= EthWords) begin
          if (h == CksumIndex) begin
            cksum_d = w;
          end else begin
            sum_d = sum_fold;
          end
          if (h == ProtoIndex) begin
            proto_d = w[7:0];
          end
          if (h == SrcIpHi || h == SrcIpLo) begin
            src_d = {src_q[15:0], w};
          end
          if (h == DstIpHi || h == DstIpLo) begin
            dest_d = {dest_q[15:0], w};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      sum_q   <= '0;
      cksum_q <= '0;
      dest_q  <= '0;
      src_q   <= '0;
      mac_q   <= '0;
      proto_q <= '0;
    end else begin
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      cksum_q <= cksum_d;
      dest_q  <= dest_d;
      src_q   <= src_d;
      mac_q   <= mac_d;
      proto_q <= proto_d;
    end
  end

  // Result built from the post-update values of the last header word.
  assign hit  = (dest_d == cfg_i.own_ip) || (dest_d == cfg_i.broadcast_ip);
  assign good = (~sum_d) == cksum_d;

  assign res_last_o       = (pos == LastWord);
  assign res_o.addressed  = hit;
  assign res_o.protocol   = (hit && good) ? proto_d : 8'd0;
  assign res_o.sender_ip  = src_d;
  assign res_o.sender_mac = mac_d;

  `IPV4RX_ASSERT(a_done_after_last, step_i && res_last_o |=> pos_q == DonePos,
                 "position did not saturate after the last header word")
  `IPV4RX_ASSERT(a_proto_needs_hit, res_last_o && res_o.protocol != 8'd0 |-> res_o.addressed,
                 "protocol passed for a frame that is not addressed")
  `IPV4RX_ASSERT_ALWAYS(a_pos_range, pos_q <= DonePos, "word position out of range")

endmodule

`default_nettype wire

@@ verif/ipv4_header_rx_check_top_tb.sv @@
// Self-checking testbench for ipv4_header_rx_check_top: drives frames and checks headers.
// Depends on ipv4rx_pkg and the ipv4_header_rx_check_top RTL; needs nothing else.

module ipv4_header_rx_check_top_tb;
  import ipv4rx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Header checker: tracks the frame position, running ones' complement sum
  // and captured fields, and queues the header result each frame should give.
  class hdr_check_board;
    logic [31:0]     own_ip;
    logic [31:0]     bcast_ip;
    logic [PosW-1:0] word_pos;
    logic [15:0]     hdr_sum;
    logic [15:0]     frame_cksum;
    logic [31:0]     dst_ip;
    logic [31:0]     src_ip;
    logic [47:0]     src_mac;
    logic [7:0]      proto;
    ipv4rx_out_t     expected_hdrs[$];
    int unsigned     headers_due;
    int unsigned     mismatches;

    function new();
      own_ip      = '0;
      bcast_ip    = '1;
      word_pos    = '0;
      hdr_sum     = '0;
      frame_cksum = '0;
      dst_ip      = '0;
      src_ip      = '0;
      src_mac     = '0;
      proto       = '0;
      headers_due = 0;
      mismatches  = 0;
    endfunction

    // 16-bit add with end-around carry
    function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
    endfunction

    function void absorb_word(ipv4rx_in_t w);
      logic [PosW-1:0] hdr_idx;
      ipv4rx_out_t     res;
      logic            hit;
      if (w.first_word) begin
        word_pos = '0;
        hdr_sum  = '0;
      end
      if (word_pos >= DonePos) return;
      if (word_pos >= MacFirst && word_pos <= MacLast) begin
        src_mac = {src_mac[31:0], w.frame_word};
      end
      if (word_pos >= EthWords) begin
        hdr_idx = word_pos - EthWords;
        if (hdr_idx == CksumIndex) frame_cksum = w.frame_word;
        else hdr_sum = ones_add(hdr_sum, w.frame_word);
        if (hdr_idx == ProtoIndex) proto = w.frame_word[7:0];
        if (hdr_idx == SrcIpHi || hdr_idx == SrcIpLo) src_ip = {src_ip[15:0], w.frame_word};
        if (hdr_idx == DstIpHi || hdr_idx == DstIpLo) dst_ip = {dst_ip[15:0], w.frame_word};
      end
      if (word_pos == LastWord) begin
        hit            = (dst_ip == own_ip) || (dst_ip == bcast_ip);
        res.addressed  = hit;
        res.protocol   = (hit && (~hdr_sum == frame_cksum)) ? proto : 8'd0;
        res.sender_ip  = src_ip;
        res.sender_mac = src_mac;
        expected_hdrs.push_back(res);
        headers_due++;
      end
      word_pos = word_pos + 1'b1;
    endfunction

    function void compare_result(ipv4rx_out_t got);
      ipv4rx_out_t want;
      if (expected_hdrs.size() == 0) begin
        $error("unexpected header result: sender_ip %h sender_mac %h",
               got.sender_ip, got.sender_mac);
        mismatches++;
        return;
      end
      want = expected_hdrs.pop_front();
      if (got.addressed !== want.addressed) begin
        $error("addressed: expected %0d, actual %0d", want.addressed, got.addressed);
        mismatches++;
      end
      if (got.protocol !== want.protocol) begin
        $error("protocol: expected %h, actual %h", want.protocol, got.protocol);
        mismatches++;
      end
      if (got.sender_ip !== want.sender_ip) begin
        $error("sender_ip: expected %h, actual %h", want.sender_ip, got.sender_ip);
        mismatches++;
      end
      if (got.sender_mac !== want.sender_mac) begin
        $error("sender_mac: expected %h, actual %h", want.sender_mac, got.sender_mac);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  ipv4rx_in_t         in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  ipv4rx_out_t        out_data_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [31:0]        cfg_data_i;

  hdr_check_board board;
  logic [15:0]    frame_buf [0:16];
  bit             in_burst;
  int unsigned    words_sent;

  ipv4_header_rx_check_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Idle cycles ahead of one transaction; zero throughout a burst stretch.
  function automatic int unsigned draw_gap(bit burst);
    if (burst) return 0;
    return $urandom_range(0, 19);
  endfunction

  // Destination IP: mostly own or broadcast, some one-bit near misses.
  function automatic logic [31:0] pick_dest();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return board.own_ip;
    if (r < 60) return board.bcast_ip;
    if (r < 75) return board.own_ip ^ (32'd1 << $urandom_range(0, 31));
    return $urandom;
  endfunction

  // One input transaction. Called in the time step of a rising edge; returns
  // in the step of the edge that accepted it, with valid still high so that
  // a back-to-back word needs no second assignment in that step.
  task automatic send_word(input logic [15:0] word, input logic first);
    ipv4rx_in_t  w;
    int unsigned gap;
    bit          took;
    w.frame_word = word;
    w.first_word = first;
    gap = draw_gap(in_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    // decide acceptance from values that are stable at the falling edge
    do begin
      @(negedge clk_i);
      took = in_valid_i && !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    board.absorb_word(w);
  endtask

  // Fill frame_buf with an Ethernet + option-free IPv4 header.
  // fill: 0 random content, 1 all zeros, otherwise all ones.
  task automatic build_frame(input logic [31:0] dst, input bit good_ck,
                             input int unsigned fill);
    logic [15:0] sum;
    for (int i = 0; i < 17; i++) begin
      case (fill)
        0:       frame_buf[i] = 16'($urandom);
        1:       frame_buf[i] = 16'h0000;
        default: frame_buf[i] = 16'hFFFF;
      endcase
    end
    if (fill == 0 && $urandom_range(0, 3) != 0) begin
      frame_buf[EthWords - 1] = 16'h0800;   // IPv4 ethertype
      frame_buf[EthWords]     = 16'h4500;   // version 4, IHL 5
    end
    frame_buf[EthWords + DstIpHi] = dst[31:16];
    frame_buf[EthWords + DstIpLo] = dst[15:0];
    sum = '0;
    for (int i = EthWords; i < 17; i++) begin
      if (i != EthWords + CksumIndex) sum = board.ones_add(sum, frame_buf[i]);
    end
    frame_buf[EthWords + CksumIndex] = good_ck ? ~sum : ~sum ^ 16'($urandom_range(1, 65535));
  endtask

  // Send the first len words of frame_buf; mark flags word 0 as frame start.
  task automatic send_frame(input bit mark, input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_word(frame_buf[i], mark && (i == 0));
      words_sent++;
    end
  endtask

  // Words past the header: ignored by the block.
  task automatic send_trailer(input int unsigned len);
    repeat (len) send_word(16'($urandom), 1'b0);
  endtask

  // Drop valid, wait for every queued header, then let the pipeline drain.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.expected_hdrs.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Write both address registers back to back, then mirror them.
  task automatic set_addresses(input logic [31:0] own, input logic [31:0] bcast);
    bit took;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgOwnIp;
    cfg_data_i  <= own;
    do begin
      @(negedge clk_i);
      took = cfg_valid_i && cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
    cfg_index_i <= CfgBcastIp;
    cfg_data_i  <= bcast;
    do begin
      @(negedge clk_i);
      took = cfg_valid_i && cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
    cfg_valid_i    <= 1'b0;
    board.own_ip   = own;
    board.bcast_ip = bcast;
  endtask

  // Receive side: random stall windows, then take one result transaction.
  initial begin : result_sink
    int unsigned gap;
    bit          took;
    bit          out_burst;
    out_burst = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 7) == 0) out_burst = ~out_burst;
      gap = draw_gap(out_burst);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        took = out_valid_o && !out_stall_i;
        @(posedge clk_i);
      end while (!took);
      board.compare_result(out_data_o);
    end
  end

  initial begin : stimulus
    logic [31:0] own_sel;
    logic [31:0] bcast_sel;
    int unsigned kind;
    int unsigned phase_start;
    board      = new();
    words_sent = 0;
    in_burst   = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CfgOwnIp;
    cfg_data_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: right after reset, an all-ones frame with no start mark is
    // taken from word 0 and hits the reset broadcast address. Two words past
    // the header follow, then a short all-zero frame that is dropped.
    build_frame(32'hFFFF_FFFF, 1'b1, 2);
    send_frame(1'b0, 17);
    send_trailer(2);
    build_frame(32'h0000_0000, 1'b1, 1);
    send_frame(1'b1, 4);

    // Random phases, each under its own address setting; extremes first.
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: begin own_sel = 32'h0000_0000; bcast_sel = 32'hFFFF_FFFF; end
        1: begin own_sel = 32'hFFFF_FFFF; bcast_sel = 32'h0000_0000; end
        2: begin own_sel = $urandom;      bcast_sel = 32'hFFFF_FFFF; end
        3: begin own_sel = 32'h0000_0000; bcast_sel = 32'h0000_0000; end
        4: begin own_sel = $urandom;      bcast_sel = $urandom;      end
        default: begin own_sel = $urandom; bcast_sel = own_sel;      end
      endcase
      set_addresses(own_sel, bcast_sel);
      phase_start = words_sent;
      while ((words_sent - phase_start) < 240 ||
             (ph == 5 && (words_sent < 1450 || board.headers_due < 48))) begin
        kind     = $urandom_range(0, 99);
        in_burst = ($urandom_range(0, 3) == 0);
        if (kind < 70) begin
          // well-formed frame, checksum mostly right
          build_frame(pick_dest(), $urandom_range(0, 3) != 0, 0);
          send_frame(1'b1, 17);
          send_trailer($urandom_range(0, 3));
        end else if (kind < 80) begin
          // frame cut short by the next start mark
          build_frame(pick_dest(), 1'b1, 0);
          send_frame(1'b1, $urandom_range(1, 16));
        end else if (kind < 90) begin
          // noise words with random start marks
          repeat ($urandom_range(1, 5)) begin
            send_word(16'($urandom), 1'($urandom));
            words_sent++;
          end
        end else if (kind < 95) begin
          // all-zero or all-ones content
          build_frame(pick_dest(), $urandom_range(0, 1), $urandom_range(1, 2));
          send_frame(1'b1, 17);
        end else begin
          // frame without a start mark; continues whatever state is left
          build_frame(pick_dest(), 1'b1, 0);
          send_frame(1'b0, 17);
        end
      end
    end

    settle();
    if (board.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
